// File: rtl/core/mfbr_pkg.sv
// ----------------------------------------------------------------------------
// MSB-first bit reader package
// Shared types, request and status codes, and sizing constants for the
// bit reader controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mfbr_pkg;

  // Byte store sizing.
  localparam int unsigned BUFFER_BYTES = 4096;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int unsigned IDX_W        = $clog2(BUFFER_BYTES + 1);

  // Reservoir sizing.
  localparam int unsigned RES_W        = 32;
  localparam int unsigned RBITS_W      = $clog2(RES_W + 1);
  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned REFILL_BYTES = RES_W / BYTE_BITS;
  localparam int unsigned FILL_W       = $clog2(REFILL_BYTES + 1);
  localparam int unsigned SLOT_W       = $clog2(REFILL_BYTES);

  // Field widths.
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned POS_W        = 13;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_APPEND   = 3'd0,
    REQ_READ     = 3'd1,
    REQ_SKIP     = 3'd2,
    REQ_PUT_BACK = 3'd3,
    REQ_RESTART  = 3'd4
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNDERRUN = 2'd1,
    ST_REFUSED  = 2'd2
  } status_e;

  // Input word.
  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] bit_count;
    logic [RES_W-1:0]   put_value;
  } req_t;

  // Output word.
  typedef struct packed {
    logic [RES_W-1:0]   value;
    logic [COUNT_W-1:0] bits_left;
    logic [POS_W-1:0]   byte_position;
    logic [1:0]         status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic consume;
    logic fill_start;
    logic fill_run;
    logic fill_end;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_loop;
    logic n_zero;
    logic rbits_zero;
    logic fill_done;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/mfbr_ctrl.sv
// ----------------------------------------------------------------------------
// MSB-first bit reader controller
// Sequences one word at a time: capture, check and apply, the consume and
// refill loop for reads and skips, and the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire mfbr_pkg::sts_t sts_i,
  output mfbr_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOOP,
    S_FILL,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_loop ? S_LOOP : S_DONE;
      end
      S_LOOP: begin
        if (sts_i.n_zero) begin
          state_d = S_DONE;
        end else if (sts_i.rbits_zero) begin
          cmd_o.fill_start = 1'b1;
          state_d          = S_FILL;
        end else begin
          cmd_o.consume = 1'b1;
        end
      end
      S_FILL: begin
        cmd_o.fill_run = 1'b1;
        if (sts_i.fill_done) begin
          cmd_o.fill_end = 1'b1;
          state_d        = S_LOOP;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mfbr_datapath.sv
// ----------------------------------------------------------------------------
// MSB-first bit reader datapath
// Byte store, read and write indexes, the 32-bit reservoir with its shifter,
// the request checks and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbr_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mfbr_pkg::req_t req_i,
  input  wire mfbr_pkg::cmd_t cmd_i,
  output mfbr_pkg::sts_t      sts_o,
  output mfbr_pkg::rsp_t      rsp_o
);

  localparam int unsigned RES_W   = mfbr_pkg::RES_W;
  localparam int unsigned IDX_W   = mfbr_pkg::IDX_W;
  localparam int unsigned ADDR_W  = mfbr_pkg::ADDR_W;
  localparam int unsigned RBITS_W = mfbr_pkg::RBITS_W;
  localparam int unsigned FILL_W  = mfbr_pkg::FILL_W;
  localparam int unsigned SLOT_W  = mfbr_pkg::SLOT_W;
  localparam int unsigned COUNT_W = mfbr_pkg::COUNT_W;
  localparam int unsigned POS_W   = mfbr_pkg::POS_W;

  // Byte store.
  logic [7:0] mem [mfbr_pkg::BUFFER_BYTES];
  logic [7:0] mem_q;
  logic       mem_we;

  // Stream state.
  logic [IDX_W-1:0]   wi_q, wi_d;
  logic [IDX_W-1:0]   ri_q, ri_d;
  logic [RES_W-1:0]   res_q, res_d;
  logic [RBITS_W-1:0] rbits_q, rbits_d;

  // Per-word working registers.
  mfbr_pkg::req_t     req_q, req_d;
  logic [COUNT_W-1:0] n_q, n_d;
  logic [RES_W-1:0]   acc_q, acc_d;
  mfbr_pkg::status_e  status_q, status_d;
  mfbr_pkg::rsp_t     rsp_q, rsp_d;

  // Refill bookkeeping.
  logic [FILL_W-1:0]  fill_cnt_q, fill_cnt_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               rd_valid_q, rd_valid_d;
  logic               can_issue;

  // Derived values.
  logic [IDX_W-1:0]     avail;
  logic [COUNT_W-1:0]   total;
  logic [SLOT_W:0]      whole;
  logic [POS_W-1:0]     pos;
  logic                 cnt_le_res;
  logic                 cnt_le_total;
  logic [RBITS_W:0]     pb_sum;
  logic                 store_full;
  mfbr_pkg::status_e    chk_status;
  logic [RBITS_W-1:0]   m;
  logic [2*RES_W-1:0]   take_shift;
  logic [2*RES_W-1:0]   pb_shift;
  logic [RES_W-1:0]     fill_byte;

  // Bits left and read position.
  assign avail = wi_q - ri_q;
  assign total = COUNT_W'({avail, 3'b000}) + COUNT_W'(rbits_q);
  assign whole = rbits_q[RBITS_W-1:3];
  assign pos   = (ri_q > IDX_W'(whole)) ? POS_W'(ri_q - IDX_W'(whole)) : '0;

  // Request checks.
  assign cnt_le_res   = (req_q.bit_count <= COUNT_W'(RES_W));
  assign cnt_le_total = (req_q.bit_count <= total);
  assign pb_sum       = (RBITS_W+1)'(rbits_q) + (RBITS_W+1)'(req_q.bit_count[RBITS_W-1:0]);
  assign store_full   = (wi_q == IDX_W'(mfbr_pkg::BUFFER_BYTES));

  always_comb begin
    chk_status = mfbr_pkg::ST_OK;
    unique case (req_q.req_type)
      mfbr_pkg::REQ_APPEND: begin
        if (store_full) begin
          chk_status = mfbr_pkg::ST_REFUSED;
        end
      end
      mfbr_pkg::REQ_READ: begin
        if (!cnt_le_res) begin
          chk_status = mfbr_pkg::ST_REFUSED;
        end else if (!cnt_le_total) begin
          chk_status = mfbr_pkg::ST_UNDERRUN;
        end
      end
      mfbr_pkg::REQ_SKIP: begin
        if (!cnt_le_total) begin
          chk_status = mfbr_pkg::ST_UNDERRUN;
        end
      end
      mfbr_pkg::REQ_PUT_BACK: begin
        if (!cnt_le_res || (pb_sum > (RBITS_W+1)'(RES_W))) begin
          chk_status = mfbr_pkg::ST_REFUSED;
        end
      end
      mfbr_pkg::REQ_RESTART: begin
        chk_status = mfbr_pkg::ST_OK;
      end
      default: begin
        chk_status = mfbr_pkg::ST_REFUSED;
      end
    endcase
  end

  // Consume step: accumulator and reservoir shift left together.
  assign m          = (n_q < COUNT_W'(rbits_q)) ? RBITS_W'(n_q) : rbits_q;
  assign take_shift = {acc_q, res_q} << m;

  // Put back: new bits enter above the reservoir, which shifts right.
  assign pb_shift = {req_q.put_value, res_q} >> req_q.bit_count[RBITS_W-1:0];

  // Refill: a returned byte lands in its slot, first byte at the top.
  assign can_issue = (fill_cnt_q != FILL_W'(mfbr_pkg::REFILL_BYTES)) && (ri_q < wi_q);
  assign fill_byte = {mem_q, (RES_W-8)'(0)} >> {slot_q, 3'b000};

  // Status to the controller.
  always_comb begin
    sts_o.need_loop  = (chk_status == mfbr_pkg::ST_OK) &&
                       ((req_q.req_type == mfbr_pkg::REQ_READ) ||
                        (req_q.req_type == mfbr_pkg::REQ_SKIP));
    sts_o.n_zero     = (n_q == '0);
    sts_o.rbits_zero = (rbits_q == '0);
    sts_o.fill_done  = !can_issue && !rd_valid_q;
  end

  // Next-state logic for all datapath registers.
  always_comb begin
    wi_d       = wi_q;
    ri_d       = ri_q;
    res_d      = res_q;
    rbits_d    = rbits_q;
    req_d      = req_q;
    n_d        = n_q;
    acc_d      = acc_q;
    status_d   = status_q;
    rsp_d      = rsp_q;
    fill_cnt_d = fill_cnt_q;
    slot_d     = slot_q;
    rd_valid_d = 1'b0;
    mem_we     = 1'b0;

    if (cmd_i.capture) begin
      req_d = req_i;
      n_d   = req_i.bit_count;
      acc_d = '0;
    end

    if (cmd_i.exec) begin
      status_d = chk_status;
      if (chk_status == mfbr_pkg::ST_OK) begin
        case (req_q.req_type)
          mfbr_pkg::REQ_APPEND: begin
            mem_we = 1'b1;
            wi_d   = wi_q + 1'b1;
          end
          mfbr_pkg::REQ_PUT_BACK: begin
            if (req_q.bit_count != '0) begin
              res_d   = pb_shift[RES_W-1:0];
              rbits_d = pb_sum[RBITS_W-1:0];
            end
          end
          mfbr_pkg::REQ_RESTART: begin
            wi_d    = '0;
            ri_d    = '0;
            res_d   = '0;
            rbits_d = '0;
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd_i.consume) begin
      acc_d   = take_shift[2*RES_W-1:RES_W];
      res_d   = take_shift[RES_W-1:0];
      rbits_d = rbits_q - m;
      n_d     = n_q - COUNT_W'(m);
    end

    if (cmd_i.fill_start) begin
      res_d      = '0;
      fill_cnt_d = '0;
    end

    if (cmd_i.fill_run && can_issue) begin
      ri_d       = ri_q + 1'b1;
      fill_cnt_d = fill_cnt_q + 1'b1;
      slot_d     = fill_cnt_q[SLOT_W-1:0];
      rd_valid_d = 1'b1;
    end

    if (rd_valid_q) begin
      res_d = res_q | fill_byte;
    end

    if (cmd_i.fill_end) begin
      rbits_d = RBITS_W'({fill_cnt_q, 3'b000});
    end

    if (cmd_i.load_result) begin
      rsp_d.value         = ((req_q.req_type == mfbr_pkg::REQ_READ) &&
                             (status_q == mfbr_pkg::ST_OK)) ? acc_q : '0;
      rsp_d.bits_left     = total;
      rsp_d.byte_position = pos;
      rsp_d.status        = status_q;
    end
  end

  // Stream state and refill control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q       <= '0;
      ri_q       <= '0;
      res_q      <= '0;
      rbits_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      wi_q       <= wi_d;
      ri_q       <= ri_d;
      res_q      <= res_d;
      rbits_q    <= rbits_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    n_q        <= n_d;
    acc_q      <= acc_d;
    status_q   <= status_d;
    rsp_q      <= rsp_d;
    fill_cnt_q <= fill_cnt_d;
    slot_q     <= slot_d;
  end

  // Byte store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wi_q[ADDR_W-1:0]] <= req_q.data_byte;
    end
    if (cmd_i.fill_run && can_issue) begin
      mem_q <= mem[ri_q[ADDR_W-1:0]];
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// File: rtl/core/msb_first_bit_reader.sv
// ----------------------------------------------------------------------------
// MSB-first bit reader
// Reads a byte stream as bits, most significant bit first, through a 32-bit
// reservoir refilled from a 4096-byte store; supports append, read, skip,
// put back and restart.
// ----------------------------------------------------------------------------
//
//   Channel  Valid        Ready        Word
//   input    in_valid_i   in_ready_o   req_i  (mfbr_pkg::req_t)
//   output   out_valid_o  out_ready_i  rsp_o  (mfbr_pkg::rsp_t)
//
// One word is in work at a time. Append, put back, restart and refused words
// pass through capture, check and apply, and the output register. A read or
// skip adds the consume and refill loop; each refill of up to four bytes
// goes through the single registered read port of the byte store. Reset
// clears the indexes and reservoir with no clearing pass. A finished result
// waits in the output register while the next word is accepted; a stalled
// output holds only the following result.
`default_nettype none

module msb_first_bit_reader (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire mfbr_pkg::req_t req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mfbr_pkg::rsp_t      rsp_o
);

  mfbr_pkg::cmd_t cmd;
  mfbr_pkg::sts_t sts;

  // Sequencing.
  mfbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, reservoir and result.
  mfbr_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

// File: sim/msb_first_bit_reader_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit reader testbench
// Drives request words into the bit reader and checks every response word
// against a behavioral predictor of the byte store, indexes and reservoir.
// Covers empty reads, put back, refused and unknown requests, a long skip
// over a large buffer, output back-pressure, and random traffic with and without idling.
// ----------------------------------------------------------------------------

module msb_first_bit_reader_tb;

  localparam int unsigned BUFFER_BYTES = mfbr_pkg::BUFFER_BYTES;
  localparam int unsigned RES_W        = mfbr_pkg::RES_W;
  localparam int unsigned BYTE_BITS    = mfbr_pkg::BYTE_BITS;
  localparam int unsigned REFILL_BYTES = mfbr_pkg::REFILL_BYTES;
  localparam int unsigned COUNT_W      = mfbr_pkg::COUNT_W;
  localparam int unsigned POS_W        = mfbr_pkg::POS_W;

  localparam int unsigned WATCHDOG_LIMIT  = 60000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned PHASE_WORDS     = 368;
  localparam int unsigned LONG_SKIP_BYTES = 300;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  mfbr_pkg::req_t req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  mfbr_pkg::rsp_t rsp_o;

  // Predicted state of the bit reader.
  bit [7:0]    store_mem [BUFFER_BYTES];
  int unsigned wr_idx;
  int unsigned rd_idx;
  bit [31:0]   resv;
  int unsigned resv_bits;

  mfbr_pkg::rsp_t expected_rsp_q [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  bit          hold_request   = 1'b0;

  msb_first_bit_reader uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rsp_o      (rsp_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Unread bits held in the store and the reservoir together.
  function automatic int unsigned bits_avail();
    return ((wr_idx > rd_idx) ? (wr_idx - rd_idx) : 0) * BYTE_BITS + resv_bits;
  endfunction

  // Load up to four bytes from the store into the reservoir, left-aligned.
  function automatic void refill_reservoir();
    int unsigned got;
    got  = 0;
    resv = '0;
    while (got < REFILL_BYTES && rd_idx < wr_idx) begin
      resv = (resv << BYTE_BITS) | 32'(store_mem[rd_idx]);
      rd_idx++;
      got++;
    end
    resv_bits = got * BYTE_BITS;
    resv      = resv << (RES_W - resv_bits);
  endfunction

  // Pull n bits (n <= 32) out of the stream, first bit most significant.
  function automatic bit [31:0] take_bits(int unsigned n);
    bit [31:0]   acc;
    int unsigned m;
    acc = '0;
    while (n > 0) begin
      if (resv_bits == 0) begin
        refill_reservoir();
        if (resv_bits == 0) break;
      end
      m         = (n < resv_bits) ? n : resv_bits;
      acc       = (acc << m) | (resv >> (RES_W - m));
      resv      = resv << m;
      resv_bits = resv_bits - m;
      n         = n - m;
    end
    return acc;
  endfunction

  // Apply one request word to the predicted state and return its response.
  function automatic mfbr_pkg::rsp_t predict_response(mfbr_pkg::req_t w);
    mfbr_pkg::rsp_t    r;
    int unsigned       cnt;
    int unsigned       whole;
    int unsigned       pos;
    bit [31:0]         val;
    mfbr_pkg::status_e st;
    cnt = w.bit_count;
    val = '0;
    st  = mfbr_pkg::ST_OK;
    case (w.req_type)
      mfbr_pkg::REQ_APPEND: begin
        if (wr_idx >= BUFFER_BYTES) begin
          st = mfbr_pkg::ST_REFUSED;
        end else begin
          store_mem[wr_idx] = w.data_byte;
          wr_idx++;
        end
      end
      mfbr_pkg::REQ_READ: begin
        if (cnt > RES_W) st = mfbr_pkg::ST_REFUSED;
        else if (cnt > bits_avail()) st = mfbr_pkg::ST_UNDERRUN;
        else val = take_bits(cnt);
      end
      mfbr_pkg::REQ_SKIP: begin
        if (cnt > bits_avail()) begin
          st = mfbr_pkg::ST_UNDERRUN;
        end else begin
          while (cnt > RES_W) begin
            void'(take_bits(RES_W));
            cnt = cnt - RES_W;
          end
          void'(take_bits(cnt));
        end
      end
      mfbr_pkg::REQ_PUT_BACK: begin
        if (cnt > RES_W || resv_bits + cnt > RES_W) begin
          st = mfbr_pkg::ST_REFUSED;
        end else if (cnt > 0) begin
          resv      = (resv >> cnt) | (w.put_value << (RES_W - cnt));
          resv_bits = resv_bits + cnt;
        end
      end
      mfbr_pkg::REQ_RESTART: begin
        wr_idx    = 0;
        rd_idx    = 0;
        resv      = '0;
        resv_bits = 0;
      end
      default: st = mfbr_pkg::ST_REFUSED;
    endcase
    whole = resv_bits / BYTE_BITS;
    pos   = (rd_idx > whole) ? (rd_idx - whole) : 0;
    r.value         = val;
    r.bits_left     = COUNT_W'(bits_avail());
    r.byte_position = POS_W'(pos);
    r.status        = st;
    return r;
  endfunction

  // Offer one word, hold it until accepted, then record its prediction.
  task automatic send_word(mfbr_pkg::req_t w);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_i      <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp_q.push_back(predict_response(w));
  endtask

  task automatic send_op(logic [2:0] code, int unsigned count, bit [31:0] pv,
                         bit [7:0] data);
    mfbr_pkg::req_t w;
    w.req_type  = code;
    w.data_byte = data;
    w.bit_count = COUNT_W'(count);
    w.put_value = pv;
    send_word(w);
  endtask

  // Random word, mostly well-formed for the current stream state.
  function automatic mfbr_pkg::req_t random_word();
    mfbr_pkg::req_t w;
    int unsigned    avail;
    int unsigned    room;
    int unsigned    pick;
    avail = bits_avail();
    room  = RES_W - resv_bits;
    pick  = $urandom_range(0, 99);
    w.data_byte = 8'($urandom_range(0, 255));
    w.put_value = $urandom();
    w.bit_count = COUNT_W'($urandom_range(0, 65535));
    if (pick < 36 || (avail == 0 && pick < 68)) begin
      w.req_type = mfbr_pkg::REQ_APPEND;
    end else if (pick < 68) begin
      w.req_type  = mfbr_pkg::REQ_READ;
      w.bit_count = COUNT_W'($urandom_range(0, (avail < RES_W) ? avail : RES_W));
    end else if (pick < 78) begin
      w.req_type  = mfbr_pkg::REQ_SKIP;
      w.bit_count = COUNT_W'($urandom_range(0, avail));
    end else if (pick < 88) begin
      w.req_type  = mfbr_pkg::REQ_PUT_BACK;
      w.bit_count = COUNT_W'($urandom_range(0, room));
    end else if (pick < 90) begin
      w.req_type = mfbr_pkg::REQ_RESTART;
    end else begin
      // Noise: any code but restart, counts just past the limits or anywhere.
      w.req_type = 3'($urandom_range(0, 7));
      if (w.req_type == mfbr_pkg::REQ_RESTART) w.req_type = mfbr_pkg::REQ_READ;
      if ($urandom_range(0, 1)) w.bit_count = COUNT_W'(avail + $urandom_range(0, 40));
    end
    return w;
  endfunction

  // Empty stream, put back before any data, and overflow of the reservoir.
  task automatic test_empty_and_put_back();
    send_op(mfbr_pkg::REQ_READ, 1, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_SKIP, 1, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_PUT_BACK, 32, 32'hA5C3_0F81, 8'h00);
    send_op(mfbr_pkg::REQ_PUT_BACK, 1, 32'hFFFF_FFFF, 8'hFF);
    send_op(mfbr_pkg::REQ_READ, 32, $urandom(), 8'h00);
  endtask

  // Appends, reads of odd sizes, zero counts, refused and unknown requests.
  task automatic test_read_paths();
    int unsigned k;
    send_op(mfbr_pkg::REQ_APPEND, 0, $urandom(), 8'hFF);
    send_op(mfbr_pkg::REQ_APPEND, 0, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_APPEND, 0, $urandom(), 8'h80);
    send_op(mfbr_pkg::REQ_APPEND, 0, $urandom(), 8'h01);
    send_op(mfbr_pkg::REQ_APPEND, 0, $urandom(), 8'h7E);
    send_op(mfbr_pkg::REQ_READ, 0, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_READ, 3, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_READ, 13, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_SKIP, 0, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_PUT_BACK, 0, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_READ, 33, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_PUT_BACK, 33, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_PUT_BACK, 8, 32'h0000_005A, 8'h00);
    send_op(mfbr_pkg::REQ_SKIP, 65535, $urandom(), 8'h00);
    for (k = 1; k <= 3; k++) begin
      send_op(3'(mfbr_pkg::REQ_RESTART) + 3'(k), $urandom_range(0, 65535),
              $urandom(), 8'h55);
    end
    send_op(mfbr_pkg::REQ_SKIP, bits_avail(), $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_RESTART, 0, $urandom(), 8'h00);
  endtask

  // Fill a large buffer, then skip all but one bit and read past the end.
  task automatic test_long_skip();
    int unsigned k;
    for (k = 0; k < LONG_SKIP_BYTES; k++) begin
      send_op(mfbr_pkg::REQ_APPEND, 0, $urandom(), 8'($urandom_range(0, 255)));
    end
    send_op(mfbr_pkg::REQ_PUT_BACK, 16, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_SKIP, bits_avail() - 1, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_READ, 1, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_READ, 1, $urandom(), 8'h00);
    send_op(mfbr_pkg::REQ_RESTART, 0, $urandom(), 8'h00);
  endtask

  // Long output stall while words keep coming, so the input backs up.
  task automatic test_output_stall();
    int unsigned k;
    hold_request = 1'b1;
    for (k = 0; k < 16; k++) begin
      if (k % 2 == 0) begin
        send_op(mfbr_pkg::REQ_APPEND, 0, $urandom(), 8'($urandom_range(0, 255)));
      end else begin
        send_op(mfbr_pkg::REQ_READ, $urandom_range(0, 8), $urandom(), 8'h00);
      end
    end
  endtask

  task automatic test_random(int unsigned words, int unsigned send_pct,
                             int unsigned recv_pct);
    int unsigned k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (k = 0; k < words; k++) send_word(random_word());
  endtask

  // Receiver: random ready, plus a long hold-off when requested.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each response word with the oldest prediction.
  always @(posedge clk_i) begin
    mfbr_pkg::rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("unexpected response word %p", rsp_o);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (exp_rsp.value !== rsp_o.value || exp_rsp.bits_left !== rsp_o.bits_left ||
            exp_rsp.byte_position !== rsp_o.byte_position ||
            exp_rsp.status !== rsp_o.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("response error: value %h/%h bits_left %0d/%0d pos %0d/%0d st %0d/%0d",
                     exp_rsp.value, rsp_o.value, exp_rsp.bits_left, rsp_o.bits_left,
                     exp_rsp.byte_position, rsp_o.byte_position,
                     exp_rsp.status, rsp_o.status);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("msb_first_bit_reader: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Test sequence.
  initial begin
    wr_idx    = 0;
    rd_idx    = 0;
    resv      = '0;
    resv_bits = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 38;
    recv_idle_pct = 48;
    test_empty_and_put_back();
    test_read_paths();
    test_long_skip();
    test_output_stall();
    test_random(PHASE_WORDS, 38, 48);
    test_random(PHASE_WORDS, 48, 38);
    test_random(PHASE_WORDS, 0, 0);
    in_valid_i <= 1'b0;

    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("msb_first_bit_reader: match");
    end else begin
      $display("msb_first_bit_reader: mismatch");
    end
    $finish;
  end

endmodule

// File: msb_first_bit_reader.f
rtl/core/mfbr_pkg.sv
rtl/core/mfbr_ctrl.sv
rtl/core/mfbr_datapath.sv
rtl/core/msb_first_bit_reader.sv
sim/msb_first_bit_reader_tb.sv
